>>> sv/rdq_pkg.sv
// ----------------------------------------------------------------------------
// rdq_pkg
// Shared types, codes and helpers for the record deque with field search.
// ----------------------------------------------------------------------------
package rdq_pkg;

    localparam int RDQ_DEPTH_DEF = 16;

    localparam int OP_W     = 3;
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 16;
    localparam int LABEL_W  = 64;
    localparam int STATUS_W = 3;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUSH_BACK    = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT   = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_BACK     = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_FRONT    = 3'd3;
    localparam logic [OP_W-1:0] OP_SEARCH_DAY   = 3'd4;
    localparam logic [OP_W-1:0] OP_SEARCH_MONTH = 3'd5;
    localparam logic [OP_W-1:0] OP_SEARCH_YEAR  = 3'd6;
    localparam logic [OP_W-1:0] OP_SEARCH_LABEL = 3'd7;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MATCH    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_MATCH = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [LABEL_W-1:0] label;
    } record_t;

    // Controller to datapath
    typedef struct packed {
        logic                latch;       // capture request fields
        logic                push;        // store record, move pointers
        logic                pop;         // read end entry, move pointers
        logic                scan_start;  // read front entry, clear pending
        logic                scan_step;   // judge current entry, fetch next
        logic                emit_zero;   // result with empty record
        logic [STATUS_W-1:0] emit_status;
        logic                emit_pop;    // result with popped record
        logic                emit_final;  // last search result
    } rdq_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_push;
        logic is_pop;
        logic full;
        logic empty;
        logic out_free;
        logic hit;
        logic pend_valid;
        logic more;
    } rdq_stat_t;

    // Clear every byte from the first zero byte on.
    function automatic logic [LABEL_W-1:0] cut_label(input logic [LABEL_W-1:0] v);
        logic [LABEL_W-1:0] r;
        logic               ended;
        r     = '0;
        ended = 1'b0;
        for (int b = 0; b < LABEL_W / 8; b++) begin
            if (v[8*b +: 8] == 8'd0) begin
                ended = 1'b1;
            end
            if (!ended) begin
                r[8*b +: 8] = v[8*b +: 8];
            end
        end
        return r;
    endfunction

endpackage

>>> sv/rdq_req_if.sv
// ----------------------------------------------------------------------------
// rdq_req_if
// Request channel: operation plus record or search key.
// ----------------------------------------------------------------------------
interface rdq_req_if
    import rdq_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic [LABEL_W-1:0] label;

    modport source (output valid, operation, day, month, year, label, input ready);
    modport sink   (input valid, operation, day, month, year, label, output ready);
endinterface

>>> sv/rdq_rsp_if.sv
// ----------------------------------------------------------------------------
// rdq_rsp_if
// Result channel: status, record fields and last marker.
// ----------------------------------------------------------------------------
interface rdq_rsp_if
    import rdq_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [DAY_W-1:0]    out_day;
    logic [MONTH_W-1:0]  out_month;
    logic [YEAR_W-1:0]   out_year;
    logic [LABEL_W-1:0]  out_label;
    logic                last;

    modport source (output valid, status, out_day, out_month, out_year, out_label, last,
                    input ready);
    modport sink   (input valid, status, out_day, out_month, out_year, out_label, last,
                    output ready);
endinterface

>>> sv/rdq_datapath.sv
// ----------------------------------------------------------------------------
// rdq_datapath
// Record memory, ring pointers, scan comparator and result register.
// ----------------------------------------------------------------------------
module rdq_datapath
    import rdq_pkg::*;
#(
    parameter int DEPTH = RDQ_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [OP_W-1:0]     operation,
    input  logic [DAY_W-1:0]    day,
    input  logic [MONTH_W-1:0]  month,
    input  logic [YEAR_W-1:0]   year,
    input  logic [LABEL_W-1:0]  label,
    input  rdq_cmd_t            cmd,
    output rdq_stat_t           stat,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [STATUS_W-1:0] status,
    output logic [DAY_W-1:0]    out_day,
    output logic [MONTH_W-1:0]  out_month,
    output logic [YEAR_W-1:0]   out_year,
    output logic [LABEL_W-1:0]  out_label,
    output logic                last
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    record_t             mem_reg [DEPTH];
    record_t             rd_data_reg;
    record_t             key_reg;
    record_t             pend_reg;
    record_t             out_rec_reg;
    logic [OP_W-1:0]     op_reg;
    logic [PTR_W-1:0]    front_reg, front_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [PTR_W-1:0]    scan_pos_reg, scan_pos_next;
    logic                pend_valid_reg, pend_valid_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic                out_last_reg;

    logic                full, empty, out_free, hit, more;
    logic [PTR_W-1:0]    front_dec, front_inc, push_slot, pop_slot, next_pos, rd_addr;
    logic                rd_en;
    logic                load_out;
    logic [STATUS_W-1:0] load_status;
    record_t             load_rec;
    logic                load_last;

    // Position in the deque to memory slot, wrapping at DEPTH.
    function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] front,
                                                 input logic [PTR_W-1:0] pos);
        logic [PTR_W:0] sum;
        sum = {1'b0, front} + {1'b0, pos};
        if (sum >= (PTR_W+1)'(DEPTH)) begin
            sum = sum - (PTR_W+1)'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign out_free  = !out_valid_reg || out_ready;
    assign front_dec = (front_reg == '0) ? PTR_W'(DEPTH - 1) : front_reg - 1'b1;
    assign front_inc = (front_reg == PTR_W'(DEPTH - 1)) ? '0 : front_reg + 1'b1;
    assign push_slot = (op_reg == OP_PUSH_FRONT) ? front_dec
                                                 : slot_of(front_reg, count_reg[PTR_W-1:0]);
    assign pop_slot  = (op_reg == OP_POP_FRONT) ? front_reg
                     : slot_of(front_reg, PTR_W'(count_reg - 1'b1));
    assign next_pos  = scan_pos_reg + 1'b1;
    assign more      = (CNT_W'(scan_pos_reg) + CNT_W'(1)) < count_reg;

    always_comb
    begin
        unique case (op_reg)
            OP_SEARCH_DAY:   hit = (rd_data_reg.day   == key_reg.day);
            OP_SEARCH_MONTH: hit = (rd_data_reg.month == key_reg.month);
            OP_SEARCH_YEAR:  hit = (rd_data_reg.year  == key_reg.year);
            OP_SEARCH_LABEL: hit = (rd_data_reg.label == key_reg.label);
            default:         hit = 1'b0;
        endcase
    end

    assign stat.is_push    = (op_reg == OP_PUSH_BACK) || (op_reg == OP_PUSH_FRONT);
    assign stat.is_pop     = (op_reg == OP_POP_BACK) || (op_reg == OP_POP_FRONT);
    assign stat.full       = full;
    assign stat.empty      = empty;
    assign stat.out_free   = out_free;
    assign stat.hit        = hit;
    assign stat.pend_valid = pend_valid_reg;
    assign stat.more       = more;

    // Memory read port
    assign rd_en   = cmd.pop || cmd.scan_start || (cmd.scan_step && more);
    assign rd_addr = cmd.pop ? pop_slot : (cmd.scan_start ? front_reg : slot_of(front_reg, next_pos));

    // Pointer, scan and pending-match updates
    always_comb
    begin
        front_next      = front_reg;
        count_next      = count_reg;
        scan_pos_next   = scan_pos_reg;
        pend_valid_next = pend_valid_reg;
        if (cmd.push)
        begin
            count_next = count_reg + 1'b1;
            if (op_reg == OP_PUSH_FRONT)
            begin
                front_next = front_dec;
            end
        end
        if (cmd.pop)
        begin
            count_next = count_reg - 1'b1;
            if (op_reg == OP_POP_FRONT)
            begin
                front_next = front_inc;
            end
        end
        if (cmd.scan_start)
        begin
            scan_pos_next   = '0;
            pend_valid_next = 1'b0;
        end
        if (cmd.scan_step)
        begin
            if (hit)
            begin
                pend_valid_next = 1'b1;
            end
            if (more)
            begin
                scan_pos_next = next_pos;
            end
        end
    end

    // Result selection
    always_comb
    begin
        load_out    = 1'b0;
        load_status = ST_OK;
        load_rec    = '0;
        load_last   = 1'b1;
        priority if (cmd.emit_zero)
        begin
            load_out    = 1'b1;
            load_status = cmd.emit_status;
        end
        else if (cmd.emit_pop)
        begin
            load_out = 1'b1;
            load_rec = rd_data_reg;
        end
        else if (cmd.scan_step && hit && pend_valid_reg)
        begin
            // a newer match exists, so the held one is not the last
            load_out    = 1'b1;
            load_status = ST_MATCH;
            load_rec    = pend_reg;
            load_last   = 1'b0;
        end
        else if (cmd.emit_final)
        begin
            load_out = 1'b1;
            if (pend_valid_reg)
            begin
                load_status = ST_MATCH;
                load_rec    = pend_reg;
            end
            else
            begin
                load_status = ST_NO_MATCH;
            end
        end
    end

    assign out_valid_next = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg      <= '0;
            count_reg      <= '0;
            scan_pos_reg   <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            front_reg      <= front_next;
            count_reg      <= count_next;
            scan_pos_reg   <= scan_pos_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg        <= operation;
            key_reg.day   <= day;
            key_reg.month <= month;
            key_reg.year  <= year;
            key_reg.label <= cut_label(label);
        end
        if (cmd.push)
        begin
            mem_reg[push_slot] <= key_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
        if (cmd.scan_step && hit)
        begin
            pend_reg <= rd_data_reg;
        end
        if (load_out)
        begin
            out_status_reg <= load_status;
            out_rec_reg    <= load_rec;
            out_last_reg   <= load_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign out_day   = out_rec_reg.day;
    assign out_month = out_rec_reg.month;
    assign out_year  = out_rec_reg.year;
    assign out_label = out_rec_reg.label;
    assign last      = out_last_reg;

endmodule

>>> sv/rdq_controller.sv
// ----------------------------------------------------------------------------
// rdq_controller
// Sequences one request at a time: execute, pop read, scan, final result.
// ----------------------------------------------------------------------------
module rdq_controller
    import rdq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  rdq_stat_t stat,
    output rdq_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_POP  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0] state_reg, state_next;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.emit_status = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.is_push)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit_zero   = 1'b1;
                        cmd.emit_status = stat.full ? ST_FULL : ST_OK;
                        cmd.push        = !stat.full;
                        state_next      = S_IDLE;
                    end
                end
                else if (stat.empty)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit_zero   = 1'b1;
                        cmd.emit_status = stat.is_pop ? ST_EMPTY : ST_NO_MATCH;
                        state_next      = S_IDLE;
                    end
                end
                else if (stat.is_pop)
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_POP;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_POP:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_pop = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_SCAN:
            begin
                // hold when a held match must go out and the result register is busy
                if (!(stat.hit && stat.pend_valid && !stat.out_free))
                begin
                    cmd.scan_step = 1'b1;
                    if (!stat.more)
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_final = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> sv/record_deque_with_field_search.sv
// ----------------------------------------------------------------------------
// record_deque_with_field_search
// Bounded double-ended queue of date records with field search.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+------------------------------------------
//  req     | in  | valid / ready | operation, day, month, year, label
//  rsp     | out | valid / ready | status, out_day, out_month, out_year,
//          |     |               | out_label, last
//
//  Steps: latch, then execute; a pop adds a memory read, and a search
//  scans the stored records before its final result (an empty deque ends
//  at execute). The single memory read port sets the search pace, one
//  entry per cycle unless a held match waits. Each request works alone.
//  Reset: rst_n clears pointers, count and control; record memory holds
//  no reset value and needs no clearing pass.
//  Stalls: a result waits in the output register while the next request
//  is taken; work that must emit another result holds until it drains.
//
module record_deque_with_field_search
    import rdq_pkg::*;
#(
    parameter int DEPTH = RDQ_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    rdq_req_if.sink    req,
    rdq_rsp_if.source  rsp
);

    rdq_cmd_t  cmd;
    rdq_stat_t stat;

    // Sequencer: one request in flight, driven by datapath status
    rdq_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Storage, pointers, comparator and the result register
    rdq_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .operation (req.operation),
        .day       (req.day),
        .month     (req.month),
        .year      (req.year),
        .label     (req.label),
        .cmd       (cmd),
        .stat      (stat),
        .out_ready (rsp.ready),
        .out_valid (rsp.valid),
        .status    (rsp.status),
        .out_day   (rsp.out_day),
        .out_month (rsp.out_month),
        .out_year  (rsp.out_year),
        .out_label (rsp.out_label),
        .last      (rsp.last)
    );

endmodule

>>> sv/rdq_checker.sv
// ----------------------------------------------------------------------------
// rdq_checker
// Port-level checks on request and result channels, bound to the top level.
// ----------------------------------------------------------------------------
module rdq_checker
    import rdq_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [STATUS_W-1:0] status,
    input logic [DAY_W-1:0]    out_day,
    input logic [YEAR_W-1:0]   out_year,
    input logic                last
);

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(last))
        else $error("result changed while stalled");

    // one request at a time
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in work");

    // only matches can be followed by more results of the same request
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != ST_MATCH |-> last)
        else $error("non-match result without last");

    // flag results carry no record
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_FULL || status == ST_EMPTY || status == ST_NO_MATCH)
        |-> out_day == '0 && out_year == '0)
        else $error("flag result carries record data");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> status <= ST_EMPTY)
        else $error("unknown status code");

endmodule

bind record_deque_with_field_search rdq_checker u_rdq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (rsp.status),
    .out_day   (rsp.out_day),
    .out_year  (rsp.out_year),
    .last      (rsp.last)
);

>>> sim/record_deque_with_field_search_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_deque_with_field_search_tb
// Self-checking bench for the record deque: directed corner cases, then
// random push/pop/search traffic with random stalls on both channels.
// ----------------------------------------------------------------------------
module record_deque_with_field_search_tb;
    import rdq_pkg::*;

    localparam int DEPTH      = RDQ_DEPTH_DEF;
    localparam int HOLD_LEN   = 300;      // long result-side hold, in cycles
    localparam int SETTLE_LEN = 20;       // quiet cycles after the last result

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [DAY_W-1:0]    day;
        logic [MONTH_W-1:0]  month;
        logic [YEAR_W-1:0]   year;
        logic [LABEL_W-1:0]  label;
        logic                last;
    } deque_result_t;

    logic clk;
    logic rst_n;

    rdq_req_if req_ch ();
    rdq_rsp_if rsp_ch ();

    record_deque_with_field_search #(
        .DEPTH (DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the deque contents, updated when a request is accepted.
    logic [DAY_W-1:0]   shadow_day   [DEPTH];
    logic [MONTH_W-1:0] shadow_month [DEPTH];
    logic [YEAR_W-1:0]  shadow_year  [DEPTH];
    logic [LABEL_W-1:0] shadow_label [DEPTH];
    int                 head_pos;
    int                 fill;

    // Results still owed by the block, oldest first.
    deque_result_t pending_results [$];

    int fail_count;
    bit steady;       // when set, neither side inserts idle cycles
    int hold_asked;   // bumped by a test to ask for one long result hold
    int hold_served;  // caught up by the result side once the hold is done

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Keep label bytes up to the first zero byte; clear everything after it.
    function automatic logic [LABEL_W-1:0] trim_label(input logic [LABEL_W-1:0] v);
        logic [LABEL_W-1:0] r;
        bit                 done;
        r    = '0;
        done = 1'b0;
        for (int b = 0; b < LABEL_W / 8; b++)
        begin
            if (v[8*b +: 8] == 8'h00)
                done = 1'b1;
            if (!done)
                r[8*b +: 8] = v[8*b +: 8];
        end
        return r;
    endfunction

    function automatic deque_result_t make_result(input logic [STATUS_W-1:0] status,
                                                  input int slot, input bit with_rec,
                                                  input logic last);
        deque_result_t r;
        r.status = status;
        r.day    = with_rec ? shadow_day[slot]   : '0;
        r.month  = with_rec ? shadow_month[slot] : '0;
        r.year   = with_rec ? shadow_year[slot]  : '0;
        r.label  = with_rec ? shadow_label[slot] : '0;
        r.last   = last;
        return r;
    endfunction

    // Append one owed result behind the ones already waiting.
    function automatic void owe_result(input deque_result_t r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    // Apply one accepted request to the shadow deque and queue its results.
    function automatic void predict_deque_op(input logic [OP_W-1:0] op,
                                             input logic [DAY_W-1:0] d,
                                             input logic [MONTH_W-1:0] m,
                                             input logic [YEAR_W-1:0] y,
                                             input logic [LABEL_W-1:0] l);
        logic [LABEL_W-1:0] key;
        int                 slot;
        int                 hits;
        bit                 hit;
        key  = trim_label(l);
        hits = 0;
        if (op == OP_PUSH_BACK || op == OP_PUSH_FRONT)
        begin
            if (fill >= DEPTH)
            begin
                owe_result(make_result(ST_FULL, 0, 1'b0, 1'b1));
            end
            else
            begin
                if (op == OP_PUSH_BACK)
                begin
                    slot = (head_pos + fill) % DEPTH;
                end
                else
                begin
                    head_pos = (head_pos + DEPTH - 1) % DEPTH;
                    slot     = head_pos;
                end
                shadow_day[slot]   = d;
                shadow_month[slot] = m;
                shadow_year[slot]  = y;
                shadow_label[slot] = key;
                fill++;
                owe_result(make_result(ST_OK, 0, 1'b0, 1'b1));
            end
        end
        else if (op == OP_POP_BACK || op == OP_POP_FRONT)
        begin
            if (fill == 0)
            begin
                owe_result(make_result(ST_EMPTY, 0, 1'b0, 1'b1));
            end
            else
            begin
                if (op == OP_POP_BACK)
                begin
                    slot = (head_pos + fill - 1) % DEPTH;
                end
                else
                begin
                    slot     = head_pos;
                    head_pos = (head_pos + 1) % DEPTH;
                end
                fill--;
                owe_result(make_result(ST_OK, slot, 1'b1, 1'b1));
            end
        end
        else
        begin
            // Scan front to back; the final hit carries the last marker.
            for (int pos = 0; pos < fill; pos++)
            begin
                slot = (head_pos + pos) % DEPTH;
                case (op)
                    OP_SEARCH_DAY:   hit = (shadow_day[slot] == d);
                    OP_SEARCH_MONTH: hit = (shadow_month[slot] == m);
                    OP_SEARCH_YEAR:  hit = (shadow_year[slot] == y);
                    default:         hit = (shadow_label[slot] == key);
                endcase
                if (hit)
                begin
                    owe_result(make_result(ST_MATCH, slot, 1'b1, 1'b0));
                    hits++;
                end
            end
            if (hits == 0)
                owe_result(make_result(ST_NO_MATCH, 0, 1'b0, 1'b1));
            else
                pending_results[pending_results.size() - 1].last = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Offer one request after a random gap; predict it at the accepting edge.
    // Valid stays high on return so back-to-back requests need no toggle.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [DAY_W-1:0] d,
                                input logic [MONTH_W-1:0] m, input logic [YEAR_W-1:0] y,
                                input logic [LABEL_W-1:0] l);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.day       <= d;
        req_ch.month     <= m;
        req_ch.year      <= y;
        req_ch.label     <= l;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        predict_deque_op(op, d, m, y, l);
    endtask

    // Drop valid and hold the request side until every owed result is back.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls, plus one long hold when a test asks for it
    // ------------------------------------------------------------------------
    initial
    begin
        int gap;
        rsp_ch.ready <= 1'b0;
        do @(posedge clk); while (rst_n !== 1'b1);
        forever
        begin
            if (hold_asked != hold_served)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge clk);
                hold_served = hold_asked;
            end
            gap = steady ? 0 : $urandom_range(0, 11);
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (rsp_ch.valid !== 1'b1);
        end
    end

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Compare every accepted result with the oldest owed one.
    always @(posedge clk)
    begin
        deque_result_t want;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: status %0h", rsp_ch.status);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status",    64'(want.status), 64'(rsp_ch.status));
                check_field("out_day",   64'(want.day),    64'(rsp_ch.out_day));
                check_field("out_month", 64'(want.month),  64'(rsp_ch.out_month));
                check_field("out_year",  64'(want.year),   64'(rsp_ch.out_year));
                check_field("out_label", want.label,       rsp_ch.out_label);
                check_field("last",      64'(want.last),   64'(rsp_ch.last));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // A few short names so that stored labels repeat and searches hit.
    function automatic logic [LABEL_W-1:0] pool_label(input int idx, output int len);
        case (idx)
            0:
            begin
                len = 0;
                return 64'h0;
            end
            1:
            begin
                len = 2;
                return 64'h6948;                 // "Hi"
            end
            2:
            begin
                len = 3;
                return 64'h6E_6F4D;              // "Mon"
            end
            default:
            begin
                len = 8;
                return 64'h656E_696C_6461_6544;  // "Deadline"
            end
        endcase
    endfunction

    // Random label: fully random, a pool name, or a pool name with junk
    // beyond its terminating zero byte.
    function automatic logic [LABEL_W-1:0] random_label();
        logic [LABEL_W-1:0] base;
        logic [LABEL_W-1:0] junk;
        logic [LABEL_W-1:0] keep;
        int                 len;
        base = pool_label($urandom_range(0, 3), len);
        junk = {$urandom, $urandom};
        keep = (64'd1 << (8 * (len + 1))) - 64'd1;
        case ($urandom_range(0, 3))
            0:       return junk;
            1:       return base;
            default: return (base & keep) | (junk & ~keep);
        endcase
    endfunction

    function automatic logic [DAY_W-1:0] random_day();
        return DAY_W'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 31));
    endfunction

    function automatic logic [MONTH_W-1:0] random_month();
        return MONTH_W'($urandom_range(0, 1) ? $urandom_range(1, 3)
                                             : $urandom_range(0, 15));
    endfunction

    function automatic logic [YEAR_W-1:0] random_year();
        return YEAR_W'($urandom_range(0, 1) ? $urandom_range(2000, 2002)
                                            : $urandom_range(0, 65535));
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Pop both ends and search an empty deque.
    task automatic test_empty_deque();
        send_request(OP_POP_BACK,     5'd0,  4'd0, 16'd0,    64'h0);
        send_request(OP_POP_FRONT,    5'd31, 4'd15, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(OP_SEARCH_DAY,   5'd0,  4'd0, 16'd0,    64'h0);
        send_request(OP_SEARCH_LABEL, 5'd0,  4'd0, 16'd0,    64'h0);
        wait_drained();
    endtask

    // Fill from both ends with field extremes, then push at full on each end.
    task automatic test_fill_both_ends();
        logic [DAY_W-1:0]   d;
        logic [MONTH_W-1:0] m;
        logic [YEAR_W-1:0]  y;
        logic [LABEL_W-1:0] l;
        int                 len;
        for (int i = 0; i < DEPTH; i++)
        begin
            d = (i == 0) ? 5'd0 : (i == 1) ? 5'd31 : DAY_W'(i % 4);
            m = (i == 2) ? 4'd15 : (i == 3) ? 4'd0 : MONTH_W'(1 + i % 3);
            y = (i == 4) ? 16'hFFFF : (i == 5) ? 16'd0 : YEAR_W'(2000 + i % 3);
            case (i)
                6:       l = 64'hFFFF_FFFF_FFFF_FFFF;
                7:       l = 64'h0;
                8:       l = 64'hDEAD_BEEF_0000_6948;   // "Hi", junk past the zero
                9:       l = 64'h1234_5678_9ABC_DE00;   // zero first byte, junk after
                default: l = pool_label(i % 4, len);
            endcase
            send_request((i % 2) ? OP_PUSH_FRONT : OP_PUSH_BACK, d, m, y, l);
        end
        send_request(OP_PUSH_BACK,  5'd7, 4'd7, 16'd7, 64'h77);
        send_request(OP_PUSH_FRONT, 5'd8, 4'd8, 16'd8, 64'h88);
        wait_drained();
    endtask

    // Search each field on the full deque, then pop one record from each end.
    task automatic test_search_fields();
        send_request(OP_SEARCH_DAY,   5'd31, 4'd0, 16'd0,    64'h0);
        send_request(OP_SEARCH_MONTH, 5'd0,  4'd2, 16'd0,    64'h0);
        send_request(OP_SEARCH_YEAR,  5'd0,  4'd0, 16'd2001, 64'h0);
        send_request(OP_SEARCH_LABEL, 5'd0,  4'd0, 16'd0,    64'h5555_AAAA_0000_6948);
        send_request(OP_POP_BACK,     5'd0,  4'd0, 16'd0,    64'h0);
        send_request(OP_POP_FRONT,    5'd0,  4'd0, 16'd0,    64'h0);
        wait_drained();
    endtask

    // Random traffic: push/pop balance follows the fill level, and most
    // searches use a key taken from a stored record so that they hit.
    task automatic test_random_mix(input int count);
        logic [OP_W-1:0]    op;
        logic [DAY_W-1:0]   d;
        logic [MONTH_W-1:0] m;
        logic [YEAR_W-1:0]  y;
        logic [LABEL_W-1:0] l;
        int                 pick;
        int                 push_pct;
        int                 pop_pct;
        int                 slot;
        for (int n = 0; n < count; n++)
        begin
            push_pct = (fill < 4) ? 60 : (fill > 12) ? 20 : 35;
            pop_pct  = (fill < 4) ? 10 : (fill > 12) ? 40 : 30;
            pick     = $urandom_range(0, 99);
            d        = random_day();
            m        = random_month();
            y        = random_year();
            l        = random_label();
            if (pick < push_pct)
            begin
                op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
            end
            else if (pick < push_pct + pop_pct)
            begin
                op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       op = OP_SEARCH_DAY;
                    1:       op = OP_SEARCH_MONTH;
                    2:       op = OP_SEARCH_YEAR;
                    default: op = OP_SEARCH_LABEL;
                endcase
                if (fill > 0 && $urandom_range(0, 9) < 7)
                begin
                    slot = (head_pos + $urandom_range(0, fill - 1)) % DEPTH;
                    d    = shadow_day[slot];
                    m    = shadow_month[slot];
                    y    = shadow_year[slot];
                    l    = shadow_label[slot];
                end
            end
            send_request(op, d, m, y, l);
        end
    endtask

    // Hold results for a long stretch while requests keep coming, so the
    // block backs up and stalls its request side; then drain completely.
    task automatic test_backpressure();
        hold_asked++;
        test_random_mix(50);
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        fail_count  = 0;
        steady      = 1'b0;
        hold_asked  = 0;
        hold_served = 0;
        head_pos    = 0;
        fill        = 0;
        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.operation <= OP_PUSH_BACK;
        req_ch.day       <= '0;
        req_ch.month     <= '0;
        req_ch.year      <= '0;
        req_ch.label     <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_deque();
        test_fill_both_ends();
        test_search_fields();
        test_random_mix(200);
        // Run one stretch back to back on both sides.
        steady = 1'b1;
        test_random_mix(100);
        steady = 1'b0;
        test_backpressure();
        test_random_mix(100);

        // Drop valid, collect what is owed, then watch for stray results.
        wait_drained();
        repeat (SETTLE_LEN) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> filelist.f
sv/rdq_pkg.sv
sv/rdq_req_if.sv
sv/rdq_rsp_if.sv
sv/rdq_datapath.sv
sv/rdq_controller.sv
sv/record_deque_with_field_search.sv
sv/rdq_checker.sv
sim/record_deque_with_field_search_tb.sv
